// File: src/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/dets_pkg.sv
// Types and constants of the dual envelope transient shaper.
`default_nettype none

package dets_pkg;

  localparam int CHANNELS = 2;
  localparam int ENV_AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam int SMP_W    = 24;
  localparam int COEF_W   = 16;
  localparam int PUNCH_W  = 17;
  localparam int TRANS_W  = 17;
  localparam int ACC_W    = 43;
  localparam int CNT_W    = 5;
  localparam int CFG_AW   = 3;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam logic [PUNCH_W-1:0] Q_ONE      = 17'd65536;
  localparam logic [PUNCH_W-1:0] PUNCH_GATE = 17'd65;
  localparam logic [ACC_W-1:0]   ROUND_HALF = 43'd32768;

  // last count value of each bit-serial phase
  localparam logic [CNT_W-1:0] ENV_LAST   = 5'd15;
  localparam logic [CNT_W-1:0] DIV_LAST   = 5'd15;
  localparam logic [CNT_W-1:0] GAIN_LAST  = 5'd16;
  localparam logic [CNT_W-1:0] SCALE_LAST = 5'd18;

  localparam logic [CFG_AW-1:0] CFG_FAST_ATTACK  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_FAST_RELEASE = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_SLOW_ATTACK  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_SLOW_RELEASE = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_PUNCH        = 3'd4;

  localparam logic signed [SMP_W-1:0] S24_MAX = 24'sh7FFFFF;
  localparam logic signed [SMP_W-1:0] S24_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ENV,
    ST_ENV_DONE,
    ST_DIV,
    ST_GAIN_INIT,
    ST_GAIN,
    ST_SCALE_INIT,
    ST_SCALE
  } state_t;

endpackage

`default_nettype wire

// File: src/dual_envelope_transient_shaper_unit.sv
// Top level of the dual envelope transient shaper.
`default_nettype none

// Stereo transient shaper: each item carries a channel, an audio sample and its
// low-band detection sample; one result item comes back per input item. Fast and
// slow one-pole followers track |band_sample|, their ratio sets a boost of up to
// 1 + punch, and the sample is scaled and saturated to 24 bits. The datapath is
// bit serial: one shift-add multiplier pair and a restoring divider take one bit
// a cycle; an active item runs through 16 follower bits, 16 quotient bits, 17
// gain bits and 18 scale bits, with ST_ENV_DONE, ST_GAIN_INIT and ST_SCALE_INIT
// between them, and skips the quotient bits when no division is needed (fast at
// or below slow, or a ratio of one or more). With punch at or below 0.001, or an
// unused channel, an item passes through unchanged. The finished result waits
// for a free output register. One item is in work at a time; the next is taken
// while the previous result still waits in the output register.
module dual_envelope_transient_shaper_unit (
  input  wire                             clk,
  input  wire                             rst_n,
  input  wire                             in_tvalid,
  output logic                            in_tready,
  // [23:0] sample_in, [47:24] band_sample
  input  wire  [dets_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] channel
  input  wire                             in_tuser,
  output logic                            out_tvalid,
  input  wire                             out_tready,
  // [23:0] sample_out, [40:24] transient_level, [47:41] zero
  output logic [dets_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] channel_out
  output logic                            out_tuser,
  input  wire                             cfg_valid,
  output logic                            cfg_ready,
  input  wire  [dets_pkg::CFG_AW-1:0]     cfg_index,
  input  wire  [dets_pkg::PUNCH_W-1:0]    cfg_data
);
  import dets_pkg::*;

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [COEF_W-1:0]  fast_att_r, fast_rel_r, slow_att_r, slow_rel_r;
  logic [PUNCH_W-1:0] punch_cfg_r;

  logic [SMP_W-1:0] fast_env_r [CHANNELS];
  logic [SMP_W-1:0] slow_env_r [CHANNELS];

  logic                     ch_r, ch_nxt;
  logic signed [SMP_W-1:0]  smp_r, smp_nxt;
  logic [PUNCH_W-1:0]       punch_r, punch_nxt;
  logic                     bypass_r, bypass_nxt;
  logic signed [ACC_W-1:0]  acc_a_r, acc_a_nxt, acc_b_r, acc_b_nxt;
  logic signed [ACC_W-1:0]  mc_a_r, mc_a_nxt, mc_b_r, mc_b_nxt;
  logic [17:0]              mp_a_r, mp_a_nxt;
  logic [COEF_W-1:0]        mp_b_r, mp_b_nxt;
  logic [SMP_W-1:0]         den_r, den_nxt;
  logic [SMP_W:0]           rem_r, rem_nxt;
  logic [TRANS_W-1:0]       trans_r, trans_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic                     out_ch_r;
  logic [SMP_W-1:0]         out_smp_r;
  logic [TRANS_W-1:0]       out_trans_r;

  // FSM decode
  logic in_acc, step_a, step_b, out_free, env_wr;

  // input side
  logic [SMP_W-1:0]   in_smp, in_band, level, fe, se;
  logic [COEF_W-1:0]  cf, cs;
  logic [ENV_AW-1:0]  in_idx, ch_idx;
  logic [PUNCH_W-1:0] punch_sat;
  logic               active;

  // follower results and divider
  logic [SMP_W-1:0] f_env, s_env, diff, den_c;
  logic             f_gt_s, sat_q;
  logic [SMP_W:0]   rem2;
  logic             q_bit;

  // output stage
  logic [17:0]             gain;
  logic [SMP_W-1:0]        mag;
  logic [26:0]             r_mag;
  logic signed [SMP_W-1:0] shaped;

  assign cfg_ready = 1'b1;

  assign in_smp  = in_tdata[SMP_W-1:0];
  assign in_band = in_tdata[2*SMP_W-1:SMP_W];
  assign in_idx  = ENV_AW'(in_tuser);
  assign ch_idx  = ENV_AW'(ch_r);

  assign level     = in_band[SMP_W-1] ? (~in_band + 24'd1) : in_band;
  assign fe        = fast_env_r[in_idx];
  assign se        = slow_env_r[in_idx];
  assign cf        = (level > fe) ? fast_att_r : fast_rel_r;
  assign cs        = (level > se) ? slow_att_r : slow_rel_r;
  assign punch_sat = (punch_cfg_r > Q_ONE) ? Q_ONE : punch_cfg_r;
  assign active    = (32'(in_tuser) < CHANNELS) && (punch_sat > PUNCH_GATE);

  assign f_env  = acc_a_r[39:16];
  assign s_env  = acc_b_r[39:16];
  assign f_gt_s = f_env > s_env;
  assign diff   = f_env - s_env;
  assign den_c  = (s_env == '0) ? 24'd1 : s_env;
  assign sat_q  = diff >= den_c;

  assign rem2  = {rem_r[SMP_W-1:0], 1'b0};
  assign q_bit = rem2 >= {1'b0, den_r};

  assign gain  = {1'b0, Q_ONE} + {1'b0, acc_a_r[32:16]};
  assign mag   = smp_r[SMP_W-1] ? (~smp_r + 24'd1) : smp_r;
  assign r_mag = acc_a_r[42:16];

  always_comb begin
    if (bypass_r) begin
      shaped = smp_r;
    end else if (smp_r[SMP_W-1]) begin
      shaped = (r_mag > 27'd8388608) ? S24_MIN : -$signed(r_mag[SMP_W-1:0]);
    end else begin
      shaped = (r_mag > 27'd8388607) ? S24_MAX : $signed(r_mag[SMP_W-1:0]);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = active ? ST_ENV : ST_SCALE;
        end
      end
      ST_ENV:        if (cnt_r == ENV_LAST) state_nxt = ST_ENV_DONE;
      ST_ENV_DONE:   state_nxt = (f_gt_s && !sat_q) ? ST_DIV : ST_GAIN_INIT;
      ST_DIV:        if (cnt_r == DIV_LAST) state_nxt = ST_GAIN_INIT;
      ST_GAIN_INIT:  state_nxt = ST_GAIN;
      ST_GAIN:       if (cnt_r == GAIN_LAST) state_nxt = ST_SCALE_INIT;
      ST_SCALE_INIT: state_nxt = ST_SCALE;
      ST_SCALE: begin
        if ((bypass_r || cnt_r == SCALE_LAST) && out_free) state_nxt = ST_IDLE;
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_tready = 1'b0;
    step_a    = 1'b0;
    step_b    = 1'b0;
    env_wr    = 1'b0;
    case (state_r)
      ST_IDLE:     in_tready = 1'b1;
      ST_ENV: begin
        step_a = 1'b1;
        step_b = 1'b1;
      end
      ST_ENV_DONE: env_wr = 1'b1;
      ST_GAIN:     step_a = 1'b1;
      ST_SCALE:    step_a = !bypass_r && (cnt_r != SCALE_LAST);
      default:     in_tready = 1'b0;
    endcase
  end

  assign in_acc   = in_tvalid && in_tready;
  assign out_free = !out_valid_r || out_tready;

  // datapath
  always_comb begin
    ch_nxt     = ch_r;
    smp_nxt    = smp_r;
    punch_nxt  = punch_r;
    bypass_nxt = bypass_r;
    acc_a_nxt  = acc_a_r;
    acc_b_nxt  = acc_b_r;
    mc_a_nxt   = mc_a_r;
    mc_b_nxt   = mc_b_r;
    mp_a_nxt   = mp_a_r;
    mp_b_nxt   = mp_b_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    trans_nxt  = trans_r;
    cnt_nxt    = cnt_r + 5'd1;

    if (in_acc) begin
      ch_nxt     = in_tuser;
      smp_nxt    = $signed(in_smp);
      punch_nxt  = punch_sat;
      bypass_nxt = !active;
      trans_nxt  = '0;
      cnt_nxt    = '0;
      // env' = level + c * (env - level), rounded, all in Q16
      acc_a_nxt  = $signed({3'd0, level, 16'd0}) + $signed(ROUND_HALF);
      acc_b_nxt  = $signed({3'd0, level, 16'd0}) + $signed(ROUND_HALF);
      mc_a_nxt   = $signed({19'd0, fe}) - $signed({19'd0, level});
      mc_b_nxt   = $signed({19'd0, se}) - $signed({19'd0, level});
      mp_a_nxt   = {2'd0, cf};
      mp_b_nxt   = cs;
    end

    if (step_a) begin
      if (mp_a_r[0]) acc_a_nxt = acc_a_r + mc_a_r;
      mc_a_nxt = mc_a_r <<< 1;
      mp_a_nxt = mp_a_r >> 1;
    end
    if (step_b) begin
      if (mp_b_r[0]) acc_b_nxt = acc_b_r + mc_b_r;
      mc_b_nxt = mc_b_r <<< 1;
      mp_b_nxt = mp_b_r >> 1;
    end

    case (state_r)
      ST_ENV_DONE: begin
        cnt_nxt = '0;
        den_nxt = den_c;
        rem_nxt = {1'b0, diff};
        // quotient of one or more clamps straight to full scale
        trans_nxt = (f_gt_s && sat_q) ? Q_ONE : '0;
      end
      ST_DIV: begin
        rem_nxt   = q_bit ? (rem2 - {1'b0, den_r}) : rem2;
        trans_nxt = {trans_r[TRANS_W-2:0], q_bit};
      end
      ST_GAIN_INIT: begin
        cnt_nxt   = '0;
        acc_a_nxt = $signed(ROUND_HALF);
        mc_a_nxt  = $signed({26'd0, punch_r});
        mp_a_nxt  = {1'b0, trans_r};
      end
      ST_SCALE_INIT: begin
        cnt_nxt   = '0;
        acc_a_nxt = $signed(ROUND_HALF);
        mc_a_nxt  = $signed({19'd0, mag});
        mp_a_nxt  = gain;
      end
      ST_SCALE: begin
        if (cnt_r == SCALE_LAST) cnt_nxt = cnt_r;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (state_r == ST_SCALE && (bypass_r || cnt_r == SCALE_LAST) && out_free) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      fast_att_r  <= 16'hFFFF;
      fast_rel_r  <= 16'hFFFF;
      slow_att_r  <= 16'hFFFF;
      slow_rel_r  <= 16'hFFFF;
      punch_cfg_r <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        fast_env_r[i] <= '0;
        slow_env_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FAST_ATTACK:  fast_att_r  <= cfg_data[COEF_W-1:0];
          CFG_FAST_RELEASE: fast_rel_r  <= cfg_data[COEF_W-1:0];
          CFG_SLOW_ATTACK:  slow_att_r  <= cfg_data[COEF_W-1:0];
          CFG_SLOW_RELEASE: slow_rel_r  <= cfg_data[COEF_W-1:0];
          CFG_PUNCH:        punch_cfg_r <= cfg_data;
          default: ;
        endcase
      end
      if (env_wr) begin
        fast_env_r[ch_idx] <= f_env;
        slow_env_r[ch_idx] <= s_env;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r    <= cnt_nxt;
    ch_r     <= ch_nxt;
    smp_r    <= smp_nxt;
    punch_r  <= punch_nxt;
    bypass_r <= bypass_nxt;
    acc_a_r  <= acc_a_nxt;
    acc_b_r  <= acc_b_nxt;
    mc_a_r   <= mc_a_nxt;
    mc_b_r   <= mc_b_nxt;
    mp_a_r   <= mp_a_nxt;
    mp_b_r   <= mp_b_nxt;
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    trans_r  <= trans_nxt;
    if (state_r == ST_SCALE && (bypass_r || cnt_r == SCALE_LAST) && out_free) begin
      out_ch_r    <= ch_r;
      out_smp_r   <= shaped;
      out_trans_r <= trans_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ch_r;
  assign out_tdata  = {7'd0, out_trans_r, out_smp_r};

endmodule

`default_nettype wire

// File: src/dets_chk.sv
// Port-level checker for the transient shaper, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module dets_chk (
  input wire                             clk,
  input wire                             rst_n,
  input wire                             in_tvalid,
  input wire                             in_tready,
  input wire [dets_pkg::IN_DATA_W-1:0]   in_tdata,
  input wire                             in_tuser,
  input wire                             out_tvalid,
  input wire                             out_tready,
  input wire [dets_pkg::OUT_DATA_W-1:0]  out_tdata,
  input wire                             out_tuser
);
  import dets_pkg::*;

  logic [TRANS_W-1:0] trans_seen;
  logic               in_take;

  assign trans_seen = out_tdata[SMP_W+TRANS_W-1:SMP_W];
  assign in_take    = in_tvalid && in_tready;

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata) && $stable(out_tuser))
  `ASSERT_IMPLY(a_trans_range, clk, rst_n, out_tvalid, trans_seen <= Q_ONE && out_tdata[OUT_DATA_W-1:SMP_W+TRANS_W] == '0)
  `ASSERT_NEXT(a_one_in_work, clk, rst_n, in_take, !in_tready)

endmodule

bind dual_envelope_transient_shaper_unit dets_chk u_dets_chk (.*);

`default_nettype wire

// File: bench/dual_envelope_transient_shaper_unit_tb.sv
// Self-checking testbench for the dual envelope transient shaper unit.
`timescale 1ns / 100ps

module dual_envelope_transient_shaper_unit_tb;
  import dets_pkg::*;

  localparam int ITEM_TARGET = 1150;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic                chan;
    logic [SMP_W-1:0]    smp;
    logic [TRANS_W-1:0]  trans;
  } shaped_item_t;

  // Tracks coefficients and follower levels; queues the shaped items due next.
  class shaping_checker;
    logic [COEF_W-1:0]  fast_att, fast_rel, slow_att, slow_rel;
    logic [PUNCH_W-1:0] punch;
    logic [SMP_W-1:0]   fast_env [CHANNELS];
    logic [SMP_W-1:0]   slow_env [CHANNELS];
    shaped_item_t       pending_shaped[$];
    int                 mismatches;

    function new();
      fast_att = '1;
      fast_rel = '1;
      slow_att = '1;
      slow_rel = '1;
      punch = '0;
      foreach (fast_env[i]) begin
        fast_env[i] = '0;
        slow_env[i] = '0;
      end
      mismatches = 0;
    endfunction

    function void set_register(logic [CFG_AW-1:0] idx, logic [PUNCH_W-1:0] val);
      case (idx)
        CFG_FAST_ATTACK:  fast_att = val[COEF_W-1:0];
        CFG_FAST_RELEASE: fast_rel = val[COEF_W-1:0];
        CFG_SLOW_ATTACK:  slow_att = val[COEF_W-1:0];
        CFG_SLOW_RELEASE: slow_rel = val[COEF_W-1:0];
        CFG_PUNCH:        punch = val;
        default: ;
      endcase
    endfunction

    // one-pole step, attack pole when the level rises above the envelope
    function logic [SMP_W-1:0] follow_level(logic [SMP_W-1:0] env, logic [SMP_W-1:0] lvl,
                                            logic [COEF_W-1:0] att, logic [COEF_W-1:0] rel);
      logic [63:0] c, acc;
      c = (lvl > env) ? 64'(att) : 64'(rel);
      acc = c * 64'(env) + (64'd65536 - c) * 64'(lvl) + 64'd32768;
      return acc[SMP_W+15:16];
    endfunction

    function void predict_shaped(logic chan, logic [IN_DATA_W-1:0] data);
      logic signed [SMP_W-1:0] s, b;
      logic [PUNCH_W-1:0] p;
      logic [SMP_W-1:0] lvl, f, sl;
      logic [63:0] diff, den, q, gain, mag, r;
      longint sv, res;
      shaped_item_t e;
      s = data[SMP_W-1:0];
      b = data[2*SMP_W-1:SMP_W];
      p = (punch > Q_ONE) ? Q_ONE : punch;
      e.chan = chan;
      e.smp = s;
      e.trans = '0;
      if (int'(chan) < CHANNELS && p > PUNCH_GATE) begin
        lvl = b[SMP_W-1] ? (~b + 1'b1) : b;   // full-scale negative maps to 2^23
        f = follow_level(fast_env[chan], lvl, fast_att, fast_rel);
        sl = follow_level(slow_env[chan], lvl, slow_att, slow_rel);
        fast_env[chan] = f;
        slow_env[chan] = sl;
        if (f > sl) begin
          diff = 64'(f) - 64'(sl);
          den = (sl != 0) ? 64'(sl) : 64'd1;
          q = (diff << 16) / den;
          e.trans = (q > 64'(Q_ONE)) ? Q_ONE : q[TRANS_W-1:0];
        end
        gain = 64'd65536 + ((64'(e.trans) * p + 64'd32768) >> 16);
        sv = longint'(s);
        mag = (sv < 0) ? 64'(-sv) : 64'(sv);
        r = (mag * gain + 64'd32768) >> 16;
        if (sv < 0)
          res = (r > 64'd8388608) ? longint'(S24_MIN) : -longint'(r);
        else
          res = (r > 64'd8388607) ? longint'(S24_MAX) : longint'(r);
        e.smp = res[SMP_W-1:0];
      end
      pending_shaped.push_back(e);
    endfunction

    function void check_shaped(logic chan, logic [OUT_DATA_W-1:0] data);
      shaped_item_t e;
      if (pending_shaped.size() == 0) begin
        $display("%0t: result item with none expected, got channel %0d sample %0d level %0d",
                 $time, chan, $signed(data[SMP_W-1:0]), data[SMP_W+TRANS_W-1:SMP_W]);
        mismatches++;
        return;
      end
      e = pending_shaped.pop_front();
      if (chan !== e.chan) begin
        $display("%0t: channel_out expected %0d got %0d", $time, e.chan, chan);
        mismatches++;
      end
      if (data[SMP_W-1:0] !== e.smp) begin
        $display("%0t: sample_out expected %0d got %0d", $time, $signed(e.smp),
                 $signed(data[SMP_W-1:0]));
        mismatches++;
      end
      if (data[SMP_W+TRANS_W-1:SMP_W] !== e.trans) begin
        $display("%0t: transient_level expected %0d got %0d", $time, e.trans,
                 data[SMP_W+TRANS_W-1:SMP_W]);
        mismatches++;
      end
      if (data[OUT_DATA_W-1:SMP_W+TRANS_W] !== '0) begin
        $display("%0t: tdata padding expected 0 got %h", $time,
                 data[OUT_DATA_W-1:SMP_W+TRANS_W]);
        mismatches++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_AW-1:0] cfg_index;
  logic [PUNCH_W-1:0] cfg_data;

  shaping_checker shaper_check = new();
  int items_sent = 0;
  int cycles = 0;
  bit steady_send = 0;

  dual_envelope_transient_shaper_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // handshakes are sampled with pre-edge values
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready)
      shaper_check.set_register(cfg_index, cfg_data);
    if (rst_n && in_tvalid && in_tready)
      shaper_check.predict_shaped(in_tuser, in_tdata);
    if (rst_n && out_tvalid && out_tready)
      shaper_check.check_shaped(out_tuser, out_tdata);
  end

  // mostly short gaps, now and then a long one
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 20);
    return $urandom_range(21, 120);
  endfunction

  // result side stalls
  initial begin
    int n;
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 30);
      out_tready <= 1'b1;
      repeat (n) @(posedge clk);
      stall = idle_gap();
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  task automatic send_item(input logic chan, input logic signed [SMP_W-1:0] smp,
                           input logic signed [SMP_W-1:0] band);
    int gap;
    gap = steady_send ? 0 : idle_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= chan;
    in_tdata <= {band, smp};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // stop sending and wait for every outstanding item to come back
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (shaper_check.pending_shaped.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_AW-1:0] idx, input logic [PUNCH_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic load_settings(input logic [COEF_W-1:0] fa, input logic [COEF_W-1:0] fr,
                               input logic [COEF_W-1:0] sa, input logic [COEF_W-1:0] sr,
                               input logic [PUNCH_W-1:0] pn);
    write_cfg(CFG_FAST_ATTACK, PUNCH_W'(fa));
    write_cfg(CFG_FAST_RELEASE, PUNCH_W'(fr));
    write_cfg(CFG_SLOW_ATTACK, PUNCH_W'(sa));
    write_cfg(CFG_SLOW_RELEASE, PUNCH_W'(sr));
    write_cfg(CFG_PUNCH, pn);
  endtask

  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return '0;
    if (r == 1) return '1;
    if (r < 5) return COEF_W'($urandom_range(60000, 65535));
    return COEF_W'($urandom_range(0, 65535));
  endfunction

  function automatic logic [PUNCH_W-1:0] pick_punch();
    int r;
    r = $urandom_range(0, 11);
    if (r == 0) return PUNCH_W'($urandom_range(0, int'(PUNCH_GATE)));
    if (r == 1) return PUNCH_W'($urandom_range(int'(Q_ONE) + 1, 131071));
    if (r == 2) return Q_ONE;
    if (r == 3) return PUNCH_GATE + 1'b1;
    return PUNCH_W'($urandom_range(int'(PUNCH_GATE) + 1, int'(Q_ONE) - 1));
  endfunction

  // detection level swings across the whole range to provoke transients
  function automatic logic signed [SMP_W-1:0] pick_band();
    logic signed [SMP_W-1:0] v;
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return S24_MIN;
    if (r == 1) return S24_MAX;
    if (r == 2) return '0;
    v = SMP_W'($urandom);
    return v >>> $urandom_range(0, SMP_W - 1);
  endfunction

  function automatic logic signed [SMP_W-1:0] pick_sample();
    logic signed [SMP_W-1:0] v;
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return S24_MIN;
    if (r == 1) return S24_MAX;
    v = SMP_W'($urandom);
    if (r == 2) return v >>> 16;
    return v;
  endfunction

  initial begin
    int n;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: punch off, items pass through
    send_item(1'b0, S24_MAX, S24_MIN);
    send_item(1'b1, S24_MIN, S24_MAX);
    send_item(1'b0, '0, '0);
    drain_results();

    // unused register indexes must change nothing
    for (int i = int'(CFG_PUNCH) + 1; i < (1 << CFG_AW); i++)
      write_cfg(CFG_AW'(i), '1);
    send_item(1'b1, 24'sd12345, S24_MAX);
    drain_results();

    // instant fast attack, frozen slow attack, slow release to zero, full punch
    load_settings('0, '1, '1, '0, Q_ONE);
    send_item(1'b0, S24_MAX, S24_MAX);
    send_item(1'b0, S24_MIN, S24_MAX);
    send_item(1'b0, 24'sd1000, S24_MAX);
    send_item(1'b1, -24'sd3, S24_MIN);
    send_item(1'b1, 24'sd2, S24_MIN);
    send_item(1'b0, 24'sd77, '0);
    send_item(1'b0, -24'sd4000000, '0);
    drain_results();

    // punch right on the gate: envelopes hold
    write_cfg(CFG_PUNCH, PUNCH_GATE);
    send_item(1'b0, S24_MAX, S24_MIN);
    send_item(1'b1, -24'sd5, 24'sd99);
    drain_results();

    // just above the gate
    write_cfg(CFG_PUNCH, PUNCH_GATE + 1'b1);
    send_item(1'b0, 24'sd4000000, S24_MAX);
    send_item(1'b1, S24_MIN, 24'sd1);
    drain_results();

    // punch above one saturates
    write_cfg(CFG_PUNCH, '1);
    send_item(1'b0, S24_MAX, S24_MIN);
    send_item(1'b1, 24'sd3000000, S24_MAX);
    send_item(1'b1, -24'sd3000000, '0);
    drain_results();

    // all poles at zero: both followers equal the level
    load_settings('0, '0, '0, '0, Q_ONE);
    send_item(1'b0, S24_MAX, S24_MAX);
    send_item(1'b1, S24_MIN, -24'sd1);
    drain_results();

    while (items_sent < ITEM_TARGET) begin
      load_settings(pick_coef(), pick_coef(), pick_coef(), pick_coef(), pick_punch());
      steady_send = ($urandom_range(0, 3) == 0);
      n = $urandom_range(40, 140);
      repeat (n) send_item(1'($urandom_range(0, 1)), pick_sample(), pick_band());
      drain_results();
    end
    steady_send = 0;

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (shaper_check.mismatches == 0 && shaper_check.pending_shaped.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+src
src/dets_pkg.sv
src/dual_envelope_transient_shaper_unit.sv
src/dets_chk.sv
bench/dual_envelope_transient_shaper_unit_tb.sv
